### rtl/hmfr_pkg.sv
package hmfr_pkg;

  localparam int CALL_MAX_DEF = 16;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [7:0] DELIM   = 8'hC0;
  localparam logic [7:0] ESC     = 8'hDB;
  localparam logic [7:0] T_DELIM = 8'hDC;
  localparam logic [7:0] T_ESC   = 8'hDD;
  localparam logic [7:0] CTRL_MAX = 8'h0D;
  localparam logic [7:0] CMD_D   = 8'h44;
  localparam logic [7:0] CMD_I   = 8'h49;
  localparam logic [7:0] CMD_C   = 8'h43;
  localparam logic [7:0] CMD_S   = 8'h53;
  localparam logic [7:0] CHR_0   = 8'h30;
  localparam logic [7:0] CHR_1   = 8'h31;
  localparam logic [7:0] CHR_L   = 8'h4C;
  localparam logic [7:0] CHR_A   = 8'h41;
  localparam logic [7:0] CHR_Z   = 8'h5A;
  localparam logic [7:0] CHR_GT  = 8'h3E;
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [3:0] LINK_LEN = 4'd10;
  localparam logic [3:0] STBY_LEN = 4'd15;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_CMD    = 3'd1,
    PH_PORT   = 3'd2,
    PH_STREAM = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SS_SKIP  = 2'd0,
    SS_MATCH = 2'd1,
    SS_CALL  = 2'd2,
    SS_IDLE  = 2'd3
  } substate_t;

  typedef enum logic [2:0] {
    K_DATA     = 3'd0,
    K_DATA_END = 3'd1,
    K_IRS      = 3'd2,
    K_ISS      = 3'd3,
    K_CALL     = 3'd4,
    K_LINKED   = 3'd5,
    K_DISC     = 3'd6,
    K_HUNT_ERR = 3'd7
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] command;
    logic [7:0] port;
    logic [7:0] stream;
    logic       esc;
    substate_t  sub;
    logic [3:0] pos;
    logic       linked;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] port;
    logic [7:0] stream;
    logic       last;
  } result_t;

  // Text "<PACTOR STANDBY"; positions past the end repeat the last character.
  function automatic logic [7:0] stby_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:  c = 8'h3C;
      4'd1:  c = 8'h50;
      4'd2:  c = 8'h41;
      4'd3:  c = 8'h43;
      4'd4:  c = 8'h54;
      4'd5:  c = 8'h4F;
      4'd6:  c = 8'h52;
      4'd7:  c = 8'h20;
      4'd8:  c = 8'h53;
      4'd9:  c = 8'h54;
      4'd10: c = 8'h41;
      4'd11: c = 8'h4E;
      4'd12: c = 8'h44;
      4'd13: c = 8'h42;
      default: c = 8'h59;
    endcase
    return c;
  endfunction

  // Text "<LINKED TO"; positions past the end repeat the last character.
  function automatic logic [7:0] link_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0: c = 8'h3C;
      4'd1: c = 8'h4C;
      4'd2: c = 8'h49;
      4'd3: c = 8'h4E;
      4'd4: c = 8'h4B;
      4'd5: c = 8'h45;
      4'd6: c = 8'h44;
      4'd7: c = 8'h20;
      4'd8: c = 8'h54;
      default: c = 8'h4F;
    endcase
    return c;
  endfunction

endpackage

### rtl/hmfr_if.sv
interface hmfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hmfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [7:0] frame_port;
  logic [7:0] frame_stream;
  logic       is_last;
  modport source (output valid, output kind, output out_byte, output frame_port,
                  output frame_stream, output is_last, input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_port,
                  input frame_stream, input is_last, output ready);
endinterface

### rtl/hmfr_decode.sv
module hmfr_decode #(
  parameter int CALL_MAX = hmfr_pkg::CALL_MAX_DEF,
  parameter int CNT_W    = $clog2(CALL_MAX + 1)
) (
  input  hmfr_pkg::state_t  st,
  input  logic [CNT_W-1:0]  cnt,
  input  logic [7:0]        rx_byte,
  output hmfr_pkg::state_t  st_nxt,
  output logic [CNT_W-1:0]  cnt_nxt,
  output hmfr_pkg::result_t res [2],
  output logic [1:0]        res_n
);

  function automatic hmfr_pkg::result_t mk(input hmfr_pkg::kind_t k, input logic [7:0] d,
                                           input hmfr_pkg::state_t s);
    hmfr_pkg::result_t r;
    r.kind   = k;
    r.data   = d;
    r.port   = s.port;
    r.stream = s.stream;
    r.last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    hmfr_pkg::state_t  s;
    logic [CNT_W-1:0]  c;
    logic [1:0]        n;
    logic [7:0]        want;
    logic              is_cs;
    logic              done;
    hmfr_pkg::result_t r0;
    hmfr_pkg::result_t r1;
    s     = st;
    c     = cnt;
    n     = 2'd0;
    done  = 1'b0;
    want  = 8'h00;
    is_cs = (st.command == hmfr_pkg::CMD_C) || (st.command == hmfr_pkg::CMD_S);
    r0    = mk(hmfr_pkg::K_DATA, 8'h00, st);
    r1    = r0;

    case (st.phase)
      hmfr_pkg::PH_HUNT: begin
        if (rx_byte == hmfr_pkg::DELIM) begin
          s.phase  = hmfr_pkg::PH_CMD;
          s.esc    = 1'b0;
          s.sub    = hmfr_pkg::SS_SKIP;
          s.pos    = 4'd0;
          s.linked = 1'b0;
          c        = '0;
        end else begin
          r0 = mk(hmfr_pkg::K_HUNT_ERR, 8'h00, st);
          n  = 2'd1;
        end
      end
      hmfr_pkg::PH_CMD: begin
        if (rx_byte != hmfr_pkg::DELIM) begin
          s.command = rx_byte;
          s.phase   = hmfr_pkg::PH_PORT;
        end
      end
      hmfr_pkg::PH_PORT: begin
        if (rx_byte == hmfr_pkg::DELIM) begin
          s.phase = hmfr_pkg::PH_HUNT;
        end else begin
          s.port  = rx_byte;
          s.phase = hmfr_pkg::PH_STREAM;
        end
      end
      hmfr_pkg::PH_STREAM: begin
        if (rx_byte == hmfr_pkg::DELIM) begin
          s.phase = hmfr_pkg::PH_HUNT;
        end else begin
          s.stream = rx_byte;
          s.phase  = hmfr_pkg::PH_BODY;
        end
      end
      hmfr_pkg::PH_BODY: begin
        if (rx_byte == hmfr_pkg::DELIM) begin
          // Closing delimiter.
          if (st.command == hmfr_pkg::CMD_D) begin
            if (st.esc) begin
              r0 = mk(hmfr_pkg::K_DATA, hmfr_pkg::ESC, st);
              r1 = mk(hmfr_pkg::K_DATA_END, 8'h00, st);
              n  = 2'd2;
            end else begin
              r0 = mk(hmfr_pkg::K_DATA_END, 8'h00, st);
              n  = 2'd1;
            end
          end else if (st.command == hmfr_pkg::CMD_I) begin
            if (st.stream == hmfr_pkg::CHR_0) begin
              r0 = mk(hmfr_pkg::K_IRS, 8'h00, st);
              n  = 2'd1;
            end else if (st.stream == hmfr_pkg::CHR_1) begin
              r0 = mk(hmfr_pkg::K_ISS, 8'h00, st);
              n  = 2'd1;
            end
          end else if (is_cs) begin
            if (st.sub == hmfr_pkg::SS_CALL ||
                (st.sub == hmfr_pkg::SS_MATCH && st.linked && st.pos == hmfr_pkg::LINK_LEN)) begin
              r0 = mk(hmfr_pkg::K_LINKED, 8'h00, st);
              n  = 2'd1;
            end
          end
          s.phase = hmfr_pkg::PH_HUNT;
          s.esc   = 1'b0;
        end else if (st.command == hmfr_pkg::CMD_D) begin
          if (st.esc) begin
            if (rx_byte == hmfr_pkg::T_DELIM) begin
              s.esc = 1'b0;
              r0    = mk(hmfr_pkg::K_DATA, hmfr_pkg::DELIM, st);
              n     = 2'd1;
            end else if (rx_byte == hmfr_pkg::T_ESC) begin
              s.esc = 1'b0;
              r0    = mk(hmfr_pkg::K_DATA, hmfr_pkg::ESC, st);
              n     = 2'd1;
            end else if (rx_byte == hmfr_pkg::ESC) begin
              r0 = mk(hmfr_pkg::K_DATA, hmfr_pkg::ESC, st);
              n  = 2'd1;
            end else begin
              s.esc = 1'b0;
              r0    = mk(hmfr_pkg::K_DATA, hmfr_pkg::ESC, st);
              r1    = mk(hmfr_pkg::K_DATA, rx_byte, st);
              n     = 2'd2;
            end
          end else if (rx_byte == hmfr_pkg::ESC) begin
            s.esc = 1'b1;
          end else begin
            r0 = mk(hmfr_pkg::K_DATA, rx_byte, st);
            n  = 2'd1;
          end
        end else if (is_cs) begin
          // Status text: skip control bytes, match the text, then the callsign.
          if (s.sub == hmfr_pkg::SS_SKIP) begin
            if (rx_byte <= hmfr_pkg::CTRL_MAX) begin
              done = 1'b1;
            end else begin
              s.sub = hmfr_pkg::SS_MATCH;
              s.pos = 4'd0;
            end
          end
          if (!done && s.sub == hmfr_pkg::SS_MATCH) begin
            done = 1'b1;
            if (s.pos == 4'd1) begin
              s.linked = (rx_byte == hmfr_pkg::CHR_L);
            end
            if (s.linked && s.pos == hmfr_pkg::LINK_LEN) begin
              s.sub = hmfr_pkg::SS_CALL;
              c     = '0;
            end else begin
              want = s.linked ? hmfr_pkg::link_char(s.pos) : hmfr_pkg::stby_char(s.pos);
              if (rx_byte != want) begin
                s.sub = hmfr_pkg::SS_IDLE;
              end else begin
                s.pos = s.pos + 4'd1;
                if (!s.linked && s.pos == hmfr_pkg::STBY_LEN) begin
                  s.sub = hmfr_pkg::SS_IDLE;
                  r0    = mk(hmfr_pkg::K_DISC, 8'h00, st);
                  n     = 2'd1;
                end
              end
            end
          end
          if (!done && s.sub == hmfr_pkg::SS_CALL) begin
            if (rx_byte == hmfr_pkg::CHR_GT || rx_byte == hmfr_pkg::CHR_NUL) begin
              s.sub = hmfr_pkg::SS_IDLE;
              r0    = mk(hmfr_pkg::K_LINKED, 8'h00, st);
              n     = 2'd1;
            end else if (c < CNT_W'(CALL_MAX)) begin
              c = c + CNT_W'(1);
              if (rx_byte >= hmfr_pkg::CHR_A && rx_byte <= hmfr_pkg::CHR_Z) begin
                r0 = mk(hmfr_pkg::K_CALL, rx_byte + hmfr_pkg::CASE_OFS, st);
              end else begin
                r0 = mk(hmfr_pkg::K_CALL, rx_byte, st);
              end
              n = 2'd1;
            end
          end
        end
      end
      default: begin
        s.phase = hmfr_pkg::PH_HUNT;
      end
    endcase

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    r1.last = 1'b1;

    st_nxt  = s;
    cnt_nxt = c;
    res[0]  = r0;
    res[1]  = r1;
    res_n   = n;
  end

endmodule

### rtl/hmfr_result_fifo.sv
module hmfr_result_fifo #(
  parameter int DEPTH = hmfr_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hmfr_pkg::result_t push_data [2],
  input  logic [1:0]        push_n,
  output logic              space_ok,
  output logic              pop_valid,
  input  logic              pop_ready,
  output hmfr_pkg::result_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hmfr_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  // Room is kept for the largest burst one input byte can cause.
  assign space_ok  = (count_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data[0];
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_data[1];
    end
  end

endmodule

### rtl/host_mode_frame_receiver.sv
// Channel   Direction  Fields                                            Handshake
// in_ch     in         rx_byte[7:0]                                      valid/ready
// out_ch    out        kind[2:0] out_byte[7:0] frame_port[7:0]           valid/ready
//                      frame_stream[7:0] is_last
//
// One received byte is accepted per cycle while input ready is high; its results (none, one
// or two) are decoded in the same cycle and written into a four-entry result queue, which
// drives the output channel, and are registered there before they appear on it.
// Reset (synchronous, active low) returns the deframer to hunting and empties the queue.
// Input ready drops only when the queue has fewer than two free entries, so a stalled
// output side stops input requests once the queue is nearly full and nothing is dropped.
module host_mode_frame_receiver #(
  parameter int CALL_MAX = hmfr_pkg::CALL_MAX_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hmfr_in_if.sink    in_ch,
  hmfr_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CALL_MAX + 1);

  // Deframer state: frame phase, header bytes, escape flag and status-text matcher.
  hmfr_pkg::state_t  st_r, st_nxt;
  // Number of callsign bytes passed on in the current linked message.
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  hmfr_pkg::result_t dec_res [2];
  logic [1:0]        dec_n;
  logic [1:0]        push_n;
  logic              space_ok;
  logic              accept;
  hmfr_pkg::result_t head;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;
  // Results enter the queue only for a byte that is actually taken.
  assign push_n      = accept ? dec_n : 2'd0;

  hmfr_decode #(
    .CALL_MAX (CALL_MAX),
    .CNT_W    (CNT_W)
  ) u_decode (
    .st      (st_r),
    .cnt     (cnt_r),
    .rx_byte (in_ch.rx_byte),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (dec_res),
    .res_n   (dec_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= hmfr_pkg::PH_HUNT;
      st_r.command <= 8'h00;
      st_r.port    <= 8'h00;
      st_r.stream  <= 8'h00;
      st_r.esc     <= 1'b0;
      st_r.sub     <= hmfr_pkg::SS_SKIP;
      st_r.pos     <= 4'd0;
      st_r.linked  <= 1'b0;
      cnt_r        <= '0;
    end else if (accept) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  hmfr_result_fifo #(
    .DEPTH (hmfr_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (dec_res),
    .push_n    (push_n),
    .space_ok  (space_ok),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (head)
  );

  assign out_ch.kind         = head.kind;
  assign out_ch.out_byte     = head.data;
  assign out_ch.frame_port   = head.port;
  assign out_ch.frame_stream = head.stream;
  assign out_ch.is_last      = head.last;

endmodule

### tb/sv/host_mode_frame_receiver_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the host-mode frame receiver. Modem bytes are fed as input
// requests through a queue. Every accepted byte runs through a cycle-free model of the
// deframer, and the results that byte should cause are appended to an in-order queue.
// Every result request that leaves the block is compared field by field against the
// head of that queue.
module host_mode_frame_receiver_tb;
  import hmfr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_BYTES  = 1700;
  localparam int MAX_REPORTS   = 40;

  // Status texts that the modem sends in C and S frames.
  localparam logic [0:14][7:0] STBY_TXT = "<PACTOR STANDBY";
  localparam logic [0:9][7:0]  LINK_TXT = "<LINKED TO";

  // Directed opening: two hunt errors, a D frame behind a repeated delimiter with every
  // escape form and an escape left pending at the close, an ISS role frame, and a frame
  // that is cut short by a delimiter where the port byte should be.
  localparam logic [0:24][7:0] OPENING_BYTES = {
    8'h00, 8'hFF,
    8'hC0, 8'hC0, 8'h44, 8'h00, 8'hFF, 8'h78, 8'hDB, 8'hDC, 8'hDB, 8'hDD,
    8'hDB, 8'hDB, 8'h71, 8'hDB, 8'hC0,
    8'hC0, 8'h49, 8'h01, 8'h31, 8'hC0,
    8'hC0, 8'h53, 8'hC0
  };

  // One queued input byte. A set hold flag makes the sender wait until every
  // expected result has come out before it offers this byte.
  typedef struct packed {
    logic       hold;
    logic [7:0] value;
  } rx_item_t;

  logic clk;
  logic rst_n;

  hmfr_in_if  in_bus ();
  hmfr_out_if out_bus ();

  host_mode_frame_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes still to be sent, and the results that accepted bytes are still owed.
  rx_item_t rx_stream[$];
  result_t  awaited[$];

  // State of the deframer model. It mirrors what the block should hold after every
  // accepted byte.
  phase_t     rx_phase;
  logic [7:0] cur_cmd;
  logic [7:0] cur_port;
  logic [7:0] cur_stream;
  logic       esc_held;
  substate_t  st_sub;
  logic [3:0] txt_pos;
  logic [4:0] call_len;
  logic       txt_linked;

  // Results of the byte being modeled; a byte never causes more than two.
  result_t step_buf[0:1];
  int      step_n;

  // Handshake bookkeeping shared by the driver, the receiver and the checker.
  logic     byte_in_flight = 1'b0;
  logic     result_taken   = 1'b0;
  logic     send_calm      = 1'b0;
  logic     recv_calm      = 1'b0;
  int       send_gap       = 0;
  int       recv_hold      = 0;
  rx_item_t next_item;
  result_t  want_res;

  // Stimulus and run statistics.
  logic hold_next     = 1'b0;
  int   stim_bytes    = 0;
  int   ignored_bytes = 0;
  int   frames_built  = 0;
  int   status_frames = 0;
  int   bytes_taken   = 0;
  int   results_seen  = 0;
  int   mismatches    = 0;
  int   cycle_count   = 0;
  int   kind_seen[0:7];

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------

  // Every result carries the header bytes that are current when it is produced.
  task automatic emit(input kind_t k, input logic [7:0] d);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.port   = cur_port;
    r.stream = cur_stream;
    r.last   = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endtask

  // Body bytes of a D frame. A pending escape followed by a byte that is not a
  // transposed code gives the escape back as data; a second escape stays pending.
  task automatic data_step(input logic [7:0] b);
    if (esc_held) begin
      if (b == T_DELIM) begin
        esc_held = 1'b0;
        emit(K_DATA, DELIM);
      end else if (b == T_ESC) begin
        esc_held = 1'b0;
        emit(K_DATA, ESC);
      end else if (b == ESC) begin
        emit(K_DATA, ESC);
      end else begin
        esc_held = 1'b0;
        emit(K_DATA, ESC);
        emit(K_DATA, b);
      end
    end else if (b == ESC) begin
      esc_held = 1'b1;
    end else begin
      emit(K_DATA, b);
    end
  endtask

  // Body bytes of a C or S frame. Leading control bytes are skipped, then the text is
  // matched; the second character decides which text is expected. After the linked
  // text one separator byte is dropped and the callsign follows.
  task automatic status_step(input logic [7:0] b);
    logic [7:0] want;
    logic [7:0] ch;
    if (st_sub == SS_SKIP && b > CTRL_MAX) begin
      st_sub  = SS_MATCH;
      txt_pos = 4'd0;
    end
    if (st_sub == SS_MATCH) begin
      if (txt_pos == 4'd1)
        txt_linked = (b == CHR_L);
      if (txt_linked && txt_pos == LINK_LEN) begin
        st_sub   = SS_CALL;
        call_len = 5'd0;
      end else begin
        if (txt_linked)
          want = LINK_TXT[txt_pos];
        else
          want = STBY_TXT[txt_pos];
        if (b != want) begin
          st_sub = SS_IDLE;
        end else begin
          txt_pos = txt_pos + 4'd1;
          if (!txt_linked && txt_pos == STBY_LEN) begin
            st_sub = SS_IDLE;
            emit(K_DISC, 8'h00);
          end
        end
      end
    end else if (st_sub == SS_CALL) begin
      if (b == CHR_GT || b == CHR_NUL) begin
        st_sub = SS_IDLE;
        emit(K_LINKED, 8'h00);
      end else if (call_len < CALL_MAX_DEF) begin
        // Callsign bytes past the length limit are silently dropped.
        call_len = call_len + 5'd1;
        ch = (b >= CHR_A && b <= CHR_Z) ? b + CASE_OFS : b;
        emit(K_CALL, ch);
      end
    end
  endtask

  // Closing delimiter of a frame body.
  task automatic close_body();
    if (cur_cmd == CMD_D) begin
      if (esc_held)
        emit(K_DATA, ESC);
      emit(K_DATA_END, 8'h00);
    end else if (cur_cmd == CMD_I) begin
      if (cur_stream == CHR_0)
        emit(K_IRS, 8'h00);
      else if (cur_stream == CHR_1)
        emit(K_ISS, 8'h00);
    end else if (cur_cmd == CMD_C || cur_cmd == CMD_S) begin
      // A callsign in progress, or a frame closed right where the separator was
      // due, still reports the link.
      if (st_sub == SS_CALL || (st_sub == SS_MATCH && txt_linked && txt_pos == LINK_LEN))
        emit(K_LINKED, 8'h00);
    end
    rx_phase = PH_HUNT;
    esc_held = 1'b0;
  endtask

  // Models one accepted byte and appends the results it causes to the awaited queue.
  task automatic deframe_byte(input logic [7:0] b);
    step_n = 0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == DELIM) begin
          rx_phase   = PH_CMD;
          esc_held   = 1'b0;
          st_sub     = SS_SKIP;
          txt_pos    = 4'd0;
          call_len   = 5'd0;
          txt_linked = 1'b0;
        end else begin
          emit(K_HUNT_ERR, 8'h00);
        end
      end
      PH_CMD: begin
        // Repeated opening delimiters are absorbed here.
        if (b != DELIM) begin
          cur_cmd  = b;
          rx_phase = PH_PORT;
        end
      end
      PH_PORT: begin
        if (b == DELIM) begin
          rx_phase = PH_HUNT;
        end else begin
          cur_port = b;
          rx_phase = PH_STREAM;
        end
      end
      PH_STREAM: begin
        if (b == DELIM) begin
          rx_phase = PH_HUNT;
        end else begin
          cur_stream = b;
          rx_phase   = PH_BODY;
        end
      end
      default: begin
        if (b == DELIM)
          close_body();
        else if (cur_cmd == CMD_D)
          data_step(b);
        else if (cur_cmd == CMD_C || cur_cmd == CMD_S)
          status_step(b);
      end
    endcase
    if (step_n > 0)
      step_buf[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      awaited.push_back(step_buf[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    rx_item_t it;
    it.hold  = hold_next;
    it.value = b;
    hold_next = 1'b0;
    rx_stream.push_back(it);
    stim_bytes++;
  endtask

  function automatic logic [7:0] any_but_delim();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == DELIM)
      v = DELIM + 8'd1;
    return v;
  endfunction

  // Opening delimiter, sometimes repeated, then the three header bytes.
  task automatic open_frame(input logic [7:0] cmd, input logic [7:0] strm);
    push_byte(DELIM);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) push_byte(DELIM);
    push_byte(cmd);
    push_byte(any_but_delim());
    push_byte(strm);
    frames_built++;
  endtask

  // Appends one random frame. Most frames are well formed with random contents so
  // that the status matcher and the callsign path are reached often; the rest are
  // unknown commands, headers cut short, and bytes outside any frame.
  task automatic add_random_frame();
    int         sel;
    int         len;
    int         cut;
    logic [7:0] b;
    logic [7:0] t;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      open_frame(CMD_D, any_but_delim());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: b = ESC;
          3:       b = T_DELIM;
          4:       b = T_ESC;
          default: b = any_but_delim();
        endcase
        push_byte(b);
      end
      if ($urandom_range(0, 4) == 0)
        push_byte(ESC);
      push_byte(DELIM);
    end else if (sel < 40) begin
      case ($urandom_range(0, 2))
        0:       b = CHR_0;
        1:       b = CHR_1;
        default: b = any_but_delim();
      endcase
      open_frame(CMD_I, b);
      len = $urandom_range(0, 3);
      repeat (len) push_byte(any_but_delim());
      ignored_bytes += len;
      push_byte(DELIM);
    end else if (sel < 78) begin
      status_frames++;
      open_frame(($urandom_range(0, 1) == 0) ? CMD_C : CMD_S, any_but_delim());
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 13)));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          for (int i = 0; i < 10; i++)
            push_byte(LINK_TXT[i]);
          // Now and then the frame closes right where the separator is due.
          if ($urandom_range(0, 7) != 0) begin
            push_byte(any_but_delim());
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 10);
            repeat (len) begin
              case ($urandom_range(0, 3))
                0:       b = 8'($urandom_range(CHR_A, CHR_Z));
                1:       b = 8'($urandom_range(CHR_A, CHR_Z)) + CASE_OFS;
                2:       b = 8'($urandom_range(CHR_0, CHR_0 + 9));
                default: begin
                  b = any_but_delim();
                  if (b == CHR_GT || b == CHR_NUL)
                    b = CHR_A;
                end
              endcase
              push_byte(b);
            end
            case ($urandom_range(0, 2))
              0: push_byte(CHR_GT);
              1: push_byte(CHR_NUL);
              default: ;
            endcase
          end
        end
        5, 6, 7: begin
          for (int i = 0; i < 15; i++)
            push_byte(STBY_TXT[i]);
          repeat ($urandom_range(0, 3)) push_byte(any_but_delim());
        end
        default: begin
          // Status text that goes wrong at a random point.
          if ($urandom_range(0, 1) == 0) begin
            cut = $urandom_range(0, 9);
            for (int i = 0; i < cut; i++)
              push_byte(LINK_TXT[i]);
            t = LINK_TXT[cut];
          end else begin
            cut = $urandom_range(0, 14);
            for (int i = 0; i < cut; i++)
              push_byte(STBY_TXT[i]);
            t = STBY_TXT[cut];
          end
          b = any_but_delim();
          if (b == t)
            b = b ^ 8'h01;
          push_byte(b);
          repeat ($urandom_range(0, 4)) push_byte(any_but_delim());
        end
      endcase
      push_byte(DELIM);
    end else if (sel < 86) begin
      b = any_but_delim();
      if (b == CMD_D || b == CMD_I || b == CMD_C || b == CMD_S)
        b = 8'h00;
      open_frame(b, any_but_delim());
      len = $urandom_range(0, 8);
      repeat (len) push_byte(any_but_delim());
      ignored_bytes += len;
      push_byte(DELIM);
    end else if (sel < 93) begin
      // Header cut short by a delimiter in the port or the stream position.
      push_byte(DELIM);
      if ($urandom_range(0, 3) == 0)
        push_byte(DELIM);
      push_byte(any_but_delim());
      if ($urandom_range(0, 1) == 0)
        push_byte(any_but_delim());
      push_byte(DELIM);
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(any_but_delim());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] result %0d: %s expected %h, got %h", $time, results_seen, what,
               want_v, got_v);
    mismatches++;
  endtask

  // Outputs are sampled at the rising edge. Results are checked before the byte
  // accepted at the same edge is modeled; that byte's results can only show up later.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (!$isunknown(out_bus.kind))
          kind_seen[out_bus.kind]++;
        if (awaited.size() == 0) begin
          report_mismatch("result with nothing awaited, kind", 8'h00, {5'd0, out_bus.kind});
        end else begin
          want_res = awaited.pop_front();
          if (out_bus.kind !== want_res.kind)
            report_mismatch("kind", {5'd0, want_res.kind}, {5'd0, out_bus.kind});
          if (out_bus.out_byte !== want_res.data)
            report_mismatch("out_byte", want_res.data, out_bus.out_byte);
          if (out_bus.frame_port !== want_res.port)
            report_mismatch("frame_port", want_res.port, out_bus.frame_port);
          if (out_bus.frame_stream !== want_res.stream)
            report_mismatch("frame_stream", want_res.stream, out_bus.frame_stream);
          if (out_bus.is_last !== want_res.last)
            report_mismatch("is_last", {7'd0, want_res.last}, {7'd0, out_bus.is_last});
        end
        results_seen++;
        result_taken = 1'b1;
      end
      if (in_bus.valid && in_bus.ready) begin
        deframe_byte(in_bus.rx_byte);
        bytes_taken++;
        byte_in_flight = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  // Inputs change on the falling edge. A request stays up until the checker sees it
  // accepted; the gap before the next one is drawn when this one is offered. Calm
  // stretches with no gaps come and go at random. A byte marked hold waits until
  // the block has delivered everything it owes.
  always @(negedge clk) begin
    if (rst_n && !byte_in_flight) begin
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (rx_stream.size() > 0 && (!rx_stream[0].hold || awaited.size() == 0)) begin
        next_item = rx_stream.pop_front();
        in_bus.rx_byte <= next_item.value;
        in_bus.valid   <= 1'b1;
        byte_in_flight = 1'b1;
        if ($urandom_range(0, 39) == 0)
          send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 6);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------------

  // After each accepted result request the receiver draws a stall and holds ready
  // low for that many cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (result_taken) begin
        result_taken = 1'b0;
        if ($urandom_range(0, 39) == 0)
          recv_calm = !recv_calm;
        recv_hold = recv_calm ? 0 : $urandom_range(0, 6);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("Timeout after %0d cycles with %0d bytes unsent and %0d results owed",
             cycle_count, rx_stream.size(), awaited.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = 8'h00;
    out_bus.ready  = 1'b0;
    for (int k = 0; k < 8; k++)
      kind_seen[k] = 0;

    // Model state after reset.
    rx_phase   = PH_HUNT;
    cur_cmd    = 8'h00;
    cur_port   = 8'h00;
    cur_stream = 8'h00;
    esc_held   = 1'b0;
    st_sub     = SS_SKIP;
    txt_pos    = 4'd0;
    call_len   = 5'd0;
    txt_linked = 1'b0;

    for (int i = 0; i < 25; i++)
      push_byte(OPENING_BYTES[i]);
    // The first random frame waits for the directed part to drain completely; a few
    // more such pauses fall at random.
    hold_next = 1'b1;
    while (stim_bytes - ignored_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 59) == 0)
        hold_next = 1'b1;
      add_random_frame();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_stream.size() > 0 || byte_in_flight)
      @(posedge clk);
    while (awaited.size() > 0)
      @(posedge clk);
    // Give any stray result time to surface.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames (%0d status frames) and checked %0d results.",
             bytes_taken, frames_built, status_frames, results_seen);
    $display("Seen: data %0d, end %0d, irs %0d, iss %0d, call %0d, linked %0d, disc %0d, hunt %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6], kind_seen[7]);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
